// ===== hdl/u8vd_pkg.sv =====
// Shared types, constants and helpers of the UTF-8 validating decoder.
package u8vd_pkg;

	localparam int unsigned QAW    = 2;
	localparam int unsigned QDEPTH = 1 << QAW;

	localparam logic [7:0]  REP_B0 = 8'hEF;
	localparam logic [7:0]  REP_B1 = 8'hBF;
	localparam logic [7:0]  REP_B2 = 8'hBD;
	localparam logic [20:0] CP_MIN2   = 21'h00080;
	localparam logic [20:0] CP_MIN3   = 21'h00800;
	localparam logic [20:0] CP_MIN4   = 21'h10000;
	localparam logic [20:0] SURR_LO   = 21'h0D800;
	localparam logic [20:0] SURR_HI   = 21'h0E000;
	localparam logic [20:0] CP_LIMIT  = 21'h110000;

	typedef struct packed {
		logic [7:0] b0;
		logic [7:0] b1;
		logic [7:0] b2;
		logic [7:0] b3;
		logic [2:0] len;
		logic       rep;
	} char_t;

	// one entry of the queue: a first character, optionally followed by a
	// second one that is either U+FFFD or a single ASCII byte
	typedef struct packed {
		char_t      first;
		logic       dual;
		logic       sec_rep;
		logic [7:0] sec_byte;
	} event_t;

	typedef struct packed {
		logic   empty;
		event_t head;
	} q_status_t;

	function automatic char_t rep_char();
		char_t c;
		c.b0  = REP_B0;
		c.b1  = REP_B1;
		c.b2  = REP_B2;
		c.b3  = 8'h00;
		c.len = 3'd3;
		c.rep = 1'b1;
		return c;
	endfunction

	function automatic char_t ascii_char(input logic [7:0] b);
		char_t c;
		c.b0  = b;
		c.b1  = 8'h00;
		c.b2  = 8'h00;
		c.b3  = 8'h00;
		c.len = 3'd1;
		c.rep = 1'b0;
		return c;
	endfunction

endpackage

// ===== hdl/u8vd_byte_if.sv =====
// Byte channel into the decoder.
interface u8vd_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       end_of_stream;

	modport source (output valid, output in_byte, output end_of_stream, input ready);
	modport sink   (input valid, input in_byte, input end_of_stream, output ready);
endinterface

// ===== hdl/u8vd_char_if.sv =====
// Character channel out of the decoder.
interface u8vd_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte0;
	logic [7:0] out_byte1;
	logic [7:0] out_byte2;
	logic [7:0] out_byte3;
	logic [2:0] out_len;
	logic       is_replacement;
	logic       last_of_run;

	modport source (output valid, output out_byte0, output out_byte1, output out_byte2,
		output out_byte3, output out_len, output is_replacement, output last_of_run,
		input ready);
	modport sink   (input valid, input out_byte0, input out_byte1, input out_byte2,
		input out_byte3, input out_len, input is_replacement, input last_of_run,
		output ready);
endinterface

// ===== hdl/u8vd_front.sv =====
// Front end: accepts bytes, tracks the pending character, classifies and queues results.
module u8vd_front (
	input  logic              clk,
	input  logic              arst_n,
	u8vd_byte_if.sink         rx,
	input  logic              q_full,
	output logic              push,
	output u8vd_pkg::event_t  push_data
);
	import u8vd_pkg::*;

	logic [2:0]  exp_len_q;
	logic [2:0]  seen_q;
	logic [20:0] acc_q;
	logic [7:0]  held_q [3];

	logic        accept;
	logic [7:0]  b;
	logic        lead_ascii, lead_bad;
	logic [2:0]  lead_len;
	logic [7:0]  lead_mask;
	logic        is_cont;
	logic [20:0] cp;
	logic [2:0]  seen_nxt;
	logic        done;
	logic        cp_bad;
	char_t       good_char;

	logic [2:0]  exp_len_d;
	logic [2:0]  seen_d;
	logic [20:0] acc_d;
	logic        held_we;
	logic [1:0]  held_idx;

	assign rx.ready = !q_full;
	assign accept   = rx.valid && rx.ready;
	assign b        = rx.in_byte;
	assign is_cont  = (b[7:6] == 2'b10);

	always_comb begin
		lead_ascii = !b[7];
		lead_bad   = (b[7:6] == 2'b10) || (b[7:1] == 7'b1111111);
		priority if (b[7:5] == 3'b110) begin
			lead_len  = 3'd2;
			lead_mask = 8'h1F;
		end else if (b[7:4] == 4'b1110) begin
			lead_len  = 3'd3;
			lead_mask = 8'h0F;
		end else if (b[7:3] == 5'b11110) begin
			lead_len  = 3'd4;
			lead_mask = 8'h07;
		end else if (b[7:2] == 6'b111110) begin
			lead_len  = 3'd5;
			lead_mask = 8'h03;
		end else begin
			lead_len  = 3'd6;
			lead_mask = 8'h01;
		end
	end

	always_comb begin
		cp       = {acc_q[14:0], b[5:0]};
		seen_nxt = seen_q + 3'd1;
		done     = (seen_nxt >= exp_len_q);
		cp_bad   = (exp_len_q > 3'd4)
			|| ((exp_len_q == 3'd2) && (cp < CP_MIN2))
			|| ((exp_len_q == 3'd3) && (cp < CP_MIN3))
			|| ((exp_len_q == 3'd4) && (cp < CP_MIN4))
			|| ((cp >= SURR_LO) && (cp < SURR_HI))
			|| (cp >= CP_LIMIT);
		good_char.rep = 1'b0;
		good_char.b0  = held_q[0];
		good_char.len = exp_len_q;
		unique case (exp_len_q)
			3'd2: begin
				good_char.b1 = b;
				good_char.b2 = 8'h00;
				good_char.b3 = 8'h00;
			end
			3'd3: begin
				good_char.b1 = held_q[1];
				good_char.b2 = b;
				good_char.b3 = 8'h00;
			end
			default: begin
				good_char.b1 = held_q[1];
				good_char.b2 = held_q[2];
				good_char.b3 = b;
			end
		endcase
	end

	always_comb begin
		exp_len_d = exp_len_q;
		seen_d    = seen_q;
		acc_d     = acc_q;
		held_we   = 1'b0;
		held_idx  = 2'd0;
		push      = 1'b0;
		push_data = '0;
		if (accept) begin
			priority if (exp_len_q == 3'd0) begin
				if (!rx.end_of_stream) begin
					priority if (lead_ascii) begin
						push            = 1'b1;
						push_data.first = ascii_char(b);
					end else if (lead_bad) begin
						push            = 1'b1;
						push_data.first = rep_char();
					end else begin
						exp_len_d = lead_len;
						seen_d    = 3'd1;
						acc_d     = {13'd0, b & lead_mask};
						held_we   = 1'b1;
					end
				end
			end else if (rx.end_of_stream) begin
				push            = 1'b1;
				push_data.first = rep_char();
				exp_len_d       = 3'd0;
				seen_d          = 3'd0;
				acc_d           = '0;
			end else if (!is_cont) begin
				push            = 1'b1;
				push_data.first = rep_char();
				exp_len_d       = 3'd0;
				seen_d          = 3'd0;
				acc_d           = '0;
				priority if (lead_ascii) begin
					push_data.dual     = 1'b1;
					push_data.sec_byte = b;
				end else if (lead_bad) begin
					push_data.dual    = 1'b1;
					push_data.sec_rep = 1'b1;
				end else begin
					exp_len_d = lead_len;
					seen_d    = 3'd1;
					acc_d     = {13'd0, b & lead_mask};
					held_we   = 1'b1;
				end
			end else begin
				held_we  = (seen_q < 3'd3);
				held_idx = seen_q[1:0];
				if (done) begin
					push            = 1'b1;
					push_data.first = cp_bad ? rep_char() : good_char;
					exp_len_d       = 3'd0;
					seen_d          = 3'd0;
					acc_d           = '0;
				end else begin
					seen_d = seen_nxt;
					acc_d  = cp;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_len_q <= 3'd0;
			seen_q    <= 3'd0;
			acc_q     <= '0;
		end else begin
			exp_len_q <= exp_len_d;
			seen_q    <= seen_d;
			acc_q     <= acc_d;
		end
	end

	always_ff @(posedge clk) begin
		if (held_we) begin
			held_q[held_idx] <= b;
		end
	end

endmodule

// ===== hdl/u8vd_queue.sv =====
// Short queue of classified results between front and back ends.
module u8vd_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  u8vd_pkg::event_t     push_data,
	output logic                 full,
	input  logic                 pop,
	output u8vd_pkg::q_status_t  status
);
	import u8vd_pkg::*;

	event_t           mem_q [QDEPTH];
	logic [QAW-1:0]   wr_ptr_q;
	logic [QAW-1:0]   rd_ptr_q;
	logic [QAW:0]     cnt_q;

	assign full         = (cnt_q == (QAW+1)'(QDEPTH));
	assign status.empty = (cnt_q == '0);
	assign status.head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// ===== hdl/u8vd_back.sv =====
// Back end: expands queued results into output beats held in an output register.
module u8vd_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  u8vd_pkg::q_status_t  status,
	output logic                 pop,
	u8vd_char_if.source          tx
);
	import u8vd_pkg::*;

	logic  valid_q;
	logic  second_q;
	char_t char_q;
	logic  last_q;

	logic  load;
	char_t sec_char;

	assign load     = !valid_q || tx.ready;
	assign sec_char = status.head.sec_rep ? rep_char() : ascii_char(status.head.sec_byte);
	assign pop      = load && !status.empty && (second_q || !status.head.dual);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= 1'b0;
			second_q <= 1'b0;
		end else if (load) begin
			valid_q <= !status.empty;
			if (!status.empty) begin
				second_q <= !second_q && status.head.dual;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && !status.empty) begin
			if (second_q) begin
				char_q <= sec_char;
				last_q <= 1'b1;
			end else begin
				char_q <= status.head.first;
				last_q <= !status.head.dual;
			end
		end
	end

	assign tx.valid          = valid_q;
	assign tx.out_byte0      = char_q.b0;
	assign tx.out_byte1      = char_q.b1;
	assign tx.out_byte2      = char_q.b2;
	assign tx.out_byte3      = char_q.b3;
	assign tx.out_len        = char_q.len;
	assign tx.is_replacement = char_q.rep;
	assign tx.last_of_run    = last_q;

endmodule

// ===== hdl/utf8_validating_decoder.sv =====
// Top level of the UTF-8 validating decoder.
//
// rx takes one beat per byte: in_byte, and end_of_stream to flush a pending
// character (in_byte is then ignored). tx gives one beat per character: up
// to four UTF-8 bytes, out_len, is_replacement for U+FFFD (EF BF BD), and
// last_of_run on the final beat caused by one input byte.
// A byte is accepted whenever the four-entry result queue has room, so the
// block takes one byte per cycle. A byte that completes a character is
// written to the queue and moves on into the output register once that
// register is free. A byte that closes a broken character and is itself
// an ASCII or invalid byte yields two beats from one queue entry, which
// the back end sends in order. When tx stalls the output register holds
// its beat, the queue fills, and rx.ready drops when all four are taken.
// Reset empties the queue, clears the output valid flag and drops any
// pending character.
module utf8_validating_decoder (
	input  logic        clk,
	input  logic        arst_n,
	u8vd_byte_if.sink   rx,
	u8vd_char_if.source tx
);
	import u8vd_pkg::*;

	logic      push;
	event_t    push_data;
	logic      q_full;
	logic      pop;
	q_status_t q_status;

	u8vd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx        (rx),
		.q_full    (q_full),
		.push      (push),
		.push_data (push_data)
	);

	u8vd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (q_full),
		.pop       (pop),
		.status    (q_status)
	);

	u8vd_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.status (q_status),
		.pop    (pop),
		.tx     (tx)
	);

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_status.empty)
		else $error("pop from empty queue");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_full)
		else $error("push into full queue");

	a_rep_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(tx.valid && tx.is_replacement) |->
			(tx.out_len == 3'd3 && tx.out_byte0 == REP_B0 && tx.out_byte3 == 8'h00))
		else $error("malformed replacement beat");

	a_first_of_pair: assert property (@(posedge clk) disable iff (!arst_n)
		(tx.valid && tx.ready && !tx.last_of_run) |=> (tx.valid && tx.last_of_run))
		else $error("second beat of a pair missing");

endmodule
